FILE: design/assert_macros.svh
// Assertion helpers; they compile to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`endif

`ifndef SYNTHESIS
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

FILE: design/thbp_pkg.sv
`timescale 1ns / 1ps

package thbp_pkg;

  localparam int unsigned INDEX_BITS      = 10;
  localparam int unsigned HISTORY_BITS    = 20;
  localparam int unsigned TABLE_COUNT     = 5;
  localparam int unsigned LONGEST_HISTORY = 20;

  localparam int unsigned HIST_W  = (HISTORY_BITS < LONGEST_HISTORY) ? HISTORY_BITS
                                                                      : LONGEST_HISTORY;
  localparam int unsigned TBL_W   = 3;
  localparam int unsigned ENTRIES = 1 << INDEX_BITS;
  localparam int unsigned SLOT_W  = TBL_W + INDEX_BITS;
  localparam int unsigned SLOT_COUNT = TABLE_COUNT * ENTRIES;

  typedef logic [1:0]            ctr_t;
  typedef logic [TBL_W-1:0]      tbl_t;
  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [HIST_W-1:0]     hist_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [4:0]            len_t;
  typedef logic [63:0]           pc_t;

  localparam ctr_t  CTR_MAX    = 2'd3;
  localparam ctr_t  CTR_INIT   = 2'd2;
  localparam tbl_t  NO_MATCH   = 3'd5;
  localparam tbl_t  LAST_TABLE = tbl_t'(TABLE_COUNT - 1);
  localparam slot_t SLOT_LAST  = slot_t'(SLOT_COUNT - 1);

  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_LOOKUP  = 5'b00100,
    ST_COMPARE = 5'b01000,
    ST_UPDATE  = 5'b10000
  } state_e;

  function automatic len_t hist_len(input tbl_t t);
    len_t len;
    case (t)
      3'd0:    len = 5'd2;
      3'd1:    len = 5'd4;
      3'd2:    len = 5'd8;
      3'd3:    len = 5'd12;
      default: len = 5'd20;
    endcase
    return len;
  endfunction

  function automatic idx_t slot_index(input tbl_t t, input pc_t pc, input hist_t h);
    hist_t m;
    m = ~(hist_t'('1) << hist_len(t));
    return pc[INDEX_BITS-1:0] ^ idx_t'(h & m);
  endfunction

  function automatic idx_t slot_tag(input tbl_t t, input pc_t pc);
    return idx_t'(pc >> hist_len(t));
  endfunction

endpackage

FILE: design/tagged_history_branch_predictor.sv
`timescale 1ns / 1ps
// Channel   | Signals                                          | Handshake
// ----------+--------------------------------------------------+--------------------------
// request   | pc_i, taken_i                                    | start high, busy low
// result    | predicted_taken_o, matched_table_o,              | result_valid_o, 1 cycle
//           | counter_value_o                                  |
//
// One shared index/tag unit probes the tables in turn, shortest history first,
// each with a memory read, then a compare, and ends with an update.
// A request keeps busy high through the probes up to its first match (table 4
// on no match) and the update; the result strobes in the cycle busy drops.
// After reset a clearing pass writes every counter and tag,
// one counter entry per cycle; busy stays high throughout.
// The receiver cannot stall: each result is shown for exactly one cycle.

`include "assert_macros.svh"

module tagged_history_branch_predictor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  thbp_pkg::pc_t       pc_i,
  input  logic                taken_i,
  output logic                result_valid_o,
  output logic                predicted_taken_o,
  output thbp_pkg::tbl_t      matched_table_o,
  output thbp_pkg::ctr_t      counter_value_o
);
  import thbp_pkg::*;

  state_e state_q, state_d;
  slot_t  clr_q, clr_d;
  hist_t  hist_q, hist_d;
  logic   result_valid_q;

  tbl_t   t_q;
  pc_t    pc_q;
  logic   taken_q;
  tbl_t   hit_q;
  slot_t  hit_slot_q;
  ctr_t   ctr_q;
  ctr_t   ctr_rd_q;
  idx_t   tag_rd_q;
  logic   pred_q;
  tbl_t   match_q;
  ctr_t   cval_q;

  ctr_t   ctr_mem [SLOT_COUNT];
  idx_t   tag_mem [ENTRIES];

  idx_t   probe_idx, probe_tag, stored_tag;
  logic   probe_hit;
  idx_t   long_idx, long_tag;
  ctr_t   ctr_trained;

  logic   ctr_we, tag_we;
  slot_t  ctr_waddr;
  ctr_t   ctr_wdata;
  idx_t   tag_waddr, tag_wdata;

  // Shared probe unit: index and tag of the table under test.
  always_comb begin
    probe_idx  = slot_index(t_q, pc_q, hist_q);
    probe_tag  = slot_tag(t_q, pc_q);
    // only the longest table ever gets tags written; the others stay zero
    stored_tag = (t_q == LAST_TABLE) ? tag_rd_q : '0;
    probe_hit  = (stored_tag == probe_tag);
    long_idx   = slot_index(LAST_TABLE, pc_q, hist_q);
    long_tag   = slot_tag(LAST_TABLE, pc_q);
  end

  always_comb begin
    ctr_trained = ctr_q;
    if (taken_q) begin
      if (ctr_q != CTR_MAX) ctr_trained = ctr_q + 2'd1;
    end else begin
      if (ctr_q != '0) ctr_trained = ctr_q - 2'd1;
    end
  end

  always_comb begin
    ctr_we    = 1'b0;
    ctr_waddr = clr_q;
    ctr_wdata = CTR_INIT;
    tag_we    = 1'b0;
    tag_waddr = clr_q[INDEX_BITS-1:0];
    tag_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        ctr_we = 1'b1;
        tag_we = 1'b1;
      end
      ST_UPDATE: begin
        ctr_we    = (hit_q != NO_MATCH);
        ctr_waddr = hit_slot_q;
        ctr_wdata = ctr_trained;
        tag_we    = 1'b1;
        tag_waddr = long_idx;
        tag_wdata = long_tag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctr_we) ctr_mem[ctr_waddr] <= ctr_wdata;
    if (state_q == ST_LOOKUP) ctr_rd_q <= ctr_mem[{t_q, probe_idx}];
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
    if (state_q == ST_LOOKUP) tag_rd_q <= tag_mem[probe_idx];
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    hist_d  = hist_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == SLOT_LAST) state_d = ST_IDLE;
        else clr_d = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (start) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: state_d = ST_COMPARE;
      ST_COMPARE: begin
        if (probe_hit || t_q == LAST_TABLE) state_d = ST_UPDATE;
        else state_d = ST_LOOKUP;
      end
      ST_UPDATE: begin
        // shift the outcome into the history
        hist_d  = {hist_q[HIST_W-2:0], taken_q};
        state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      hist_q         <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      hist_q         <= hist_d;
      result_valid_q <= (state_q == ST_UPDATE);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        t_q     <= '0;
        pc_q    <= pc_i;
        taken_q <= taken_i;
      end
      ST_COMPARE: begin
        if (probe_hit) begin
          hit_q      <= t_q;
          hit_slot_q <= {t_q, probe_idx};
          ctr_q      <= ctr_rd_q;
        end else if (t_q == LAST_TABLE) begin
          hit_q <= NO_MATCH;
          ctr_q <= CTR_INIT;
        end else begin
          t_q <= t_q + 1'b1;
        end
      end
      ST_UPDATE: begin
        pred_q  <= ctr_q[1];
        match_q <= hit_q;
        cval_q  <= ctr_q;
      end
      default: begin
      end
    endcase
  end

  assign busy              = (state_q != ST_IDLE);
  assign result_valid_o    = result_valid_q;
  assign predicted_taken_o = pred_q;
  assign matched_table_o   = match_q;
  assign counter_value_o   = cval_q;

  `ASSERT_AT(a_update_strobes, clk_i, rst_ni, (state_q == ST_UPDATE) |=> result_valid_q)
  `ASSERT_AT(a_strobe_one_cycle, clk_i, rst_ni, result_valid_q |=> !result_valid_q)
  `ASSERT_NEVER(a_probe_range, clk_i, rst_ni,
      (state_q == ST_LOOKUP || state_q == ST_COMPARE) && (t_q > LAST_TABLE))
  `ASSERT_NEVER(a_match_range, clk_i, rst_ni, result_valid_q && (match_q > NO_MATCH))
  `ASSERT_AT(a_clear_busy, clk_i, rst_ni,
      (state_q == ST_CLEAR && clr_q != SLOT_LAST) |=> (state_q == ST_CLEAR))

endmodule
